@@ design/amm_pkg.sv @@
// ----------------------------------------------------------------------------
// amm_pkg: shared types and constants for the mean, median and mode block.
// Sizes of the value store and the result fields, and the controller states.
// ----------------------------------------------------------------------------
package amm_pkg;

   localparam int MAX_COUNT  = 64;
   localparam int VALUE_BITS = 8;
   localparam int ADDR_BITS  = $clog2(MAX_COUNT);
   localparam int CNT_BITS   = $clog2(MAX_COUNT + 1);
   localparam int SUM_BITS   = 14;
   localparam int MEAN_BITS  = 16;
   localparam int MED_BITS   = 9;
   localparam int REP_BITS   = 6;
   localparam int FRAC_BITS  = 8;
   localparam int DIVD_BITS  = SUM_BITS + FRAC_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SORT_RD_I,
      ST_SORT_RD_J,
      ST_SORT_CMP,
      ST_SORT_SHIFT,
      ST_SORT_PUT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   // Request and status between the controller and the divider.
   typedef struct packed {
      logic                 start;
      logic [SUM_BITS-1:0]  total;
      logic [CNT_BITS-1:0]  count;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [MEAN_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

@@ design/amm_ram.sv @@
// ----------------------------------------------------------------------------
// amm_ram: single-port synchronous RAM for the value store.
// One write or one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module amm_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Read first: a read of the address being written returns the old data. Read registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

@@ design/amm_div.sv @@
// ----------------------------------------------------------------------------
// amm_div: restoring divider for the mean.
// Divides total shifted up by the fraction bits by the count, one bit a cycle.
// ----------------------------------------------------------------------------
module amm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  amm_pkg::div_req_type req,
   output amm_pkg::div_rsp_type rsp
);

   localparam int DB = amm_pkg::DIVD_BITS;
   localparam int CB = amm_pkg::CNT_BITS;
   localparam int STEP_BITS = $clog2(DB + 1);

   logic [DB-1:0]        quo_ff, quo_in;
   logic [CB-1:0]        rem_ff, rem_in;
   logic [CB-1:0]        dvs_ff, dvs_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CB:0]          trial;

   // One shift and subtract step while running.
   // The remainder stays below the divisor, so it fits in the count width.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DB-1]};
      if (req.start) begin
         quo_in  = {req.total, {amm_pkg::FRAC_BITS{1'b0}}};
         rem_in  = '0;
         dvs_in  = req.count;
         step_in = STEP_BITS'(DB);
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = CB'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DB-2:0], 1'b1};
         end else begin
            rem_in = trial[CB-1:0];
            quo_in = {quo_ff[DB-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff[amm_pkg::MEAN_BITS-1:0];

endmodule

@@ design/array_mean_median_mode.sv @@
// ----------------------------------------------------------------------------
// array_mean_median_mode: mean, median and mode over a set of values.
// Values are stored in a RAM, insertion sorted in place, then scanned.
// ----------------------------------------------------------------------------
// Usage: drive req_sample and req_is_last with start high; a word is taken at
// the clock edge where start is high and busy is low. A word without the last
// flag is stored and busy stays low, so values load one a cycle.
// Values past 64 are dropped and reported through rsp_overflowed.
// On the word carrying the last flag the block raises busy and runs its
// sequencer over the single-port value RAM: an insertion sort reads each
// element as the key, shifts larger entries below it up one place and then
// puts the key, then a scan over the sorted values finds the median and
// mode. The mean comes from a 22-step serial divider started at the first
// sort step; the block waits for it before giving the result. The result
// appears on the rsp_ ports for one cycle with rsp_valid, after which busy
// drops and a new empty set begins. The receiver cannot stall; the result
// must be taken in that cycle. A synchronous reset returns the block to idle
// with an empty set; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
module array_mean_median_mode (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [7:0]                      req_sample,
   input  logic                            req_is_last,
   output logic                            rsp_valid,
   output logic [6:0]                      rsp_item_count,
   output logic [13:0]                     rsp_total,
   output logic [15:0]                     rsp_mean_fixed,
   output logic [8:0]                      rsp_median_doubled,
   output logic [7:0]                      rsp_mode_value,
   output logic [5:0]                      rsp_mode_repeats,
   output logic                            rsp_has_mode,
   output logic                            rsp_overflowed
);

   localparam int AB = amm_pkg::ADDR_BITS;
   localparam int CB = amm_pkg::CNT_BITS;
   localparam int VB = amm_pkg::VALUE_BITS;
   localparam int RB = amm_pkg::REP_BITS;

   amm_pkg::state_type state_ff, state_in;

   logic [CB-1:0]             count_ff, count_in;
   logic [amm_pkg::SUM_BITS-1:0] sum_ff, sum_in;
   logic                      drop_ff, drop_in;
   logic [CB-1:0]             i_ff, i_in;
   logic [CB-1:0]             j_ff, j_in;
   logic [VB-1:0]             key_ff, key_in;
   logic [VB-1:0]             prev_ff, prev_in;
   logic [RB-1:0]             run_ff, run_in;
   logic [RB-1:0]             best_rep_ff, best_rep_in;
   logic [VB-1:0]             best_val_ff, best_val_in;
   logic [amm_pkg::MED_BITS-1:0] med_ff, med_in;
   logic                      div_done_ff, div_done_in;
   logic [amm_pkg::MEAN_BITS-1:0] mean_ff, mean_in;

   logic                      ram_we;
   logic [AB-1:0]             ram_addr;
   logic [VB-1:0]             ram_wdata, ram_rdata;
   amm_pkg::div_req_type      dreq;
   amm_pkg::div_rsp_type      drsp;

   logic                      take;
   logic                      full;
   logic [CB-1:0]             n_eff;
   logic [CB-1:0]             mid_hi;
   logic [CB-1:0]             mid_lo;

   amm_ram #(.DEPTH(amm_pkg::MAX_COUNT), .WIDTH(VB)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   amm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   assign take   = start && !busy;
   assign full   = (count_ff == CB'(amm_pkg::MAX_COUNT));
   assign n_eff  = count_ff;
   assign mid_hi = n_eff >> 1;
   assign mid_lo = (n_eff[0]) ? mid_hi : mid_hi - 1'b1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         amm_pkg::ST_IDLE: begin
            if (take && req_is_last) begin
               state_in = amm_pkg::ST_SORT_RD_I;
            end
         end
         amm_pkg::ST_SORT_RD_I: begin
            if (i_ff >= n_eff) begin
               state_in = amm_pkg::ST_SCAN_RD;
            end else begin
               state_in = amm_pkg::ST_SORT_RD_J;
            end
         end
         amm_pkg::ST_SORT_RD_J: begin
            if (j_ff == '0) begin
               state_in = amm_pkg::ST_SORT_PUT;
            end else begin
               state_in = amm_pkg::ST_SORT_CMP;
            end
         end
         amm_pkg::ST_SORT_CMP: begin
            if (ram_rdata > key_ff) begin
               state_in = amm_pkg::ST_SORT_SHIFT;
            end else begin
               state_in = amm_pkg::ST_SORT_PUT;
            end
         end
         amm_pkg::ST_SORT_SHIFT: state_in = amm_pkg::ST_SORT_RD_J;
         amm_pkg::ST_SORT_PUT:   state_in = amm_pkg::ST_SORT_RD_I;
         amm_pkg::ST_SCAN_RD:    state_in = amm_pkg::ST_SCAN_CHK;
         amm_pkg::ST_SCAN_CHK: begin
            if (i_ff == n_eff) begin
               state_in = amm_pkg::ST_DIV_WAIT;
            end
         end
         amm_pkg::ST_DIV_WAIT: begin
            if (div_done_ff || drsp.done) begin
               state_in = amm_pkg::ST_DONE;
            end
         end
         amm_pkg::ST_DONE: state_in = amm_pkg::ST_IDLE;
         default:          state_in = amm_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      count_in    = count_ff;
      sum_in      = sum_ff;
      drop_in     = drop_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      key_in      = key_ff;
      prev_in     = prev_ff;
      run_in      = run_ff;
      best_rep_in = best_rep_ff;
      best_val_in = best_val_ff;
      med_in      = med_ff;
      div_done_in = div_done_ff | drsp.done;
      mean_in     = drsp.done ? drsp.quotient : mean_ff;
      ram_we      = 1'b0;
      ram_addr    = '0;
      ram_wdata   = req_sample[VB-1:0];
      dreq.start  = 1'b0;
      dreq.total  = sum_ff;
      dreq.count  = count_ff;
      case (state_ff)
         amm_pkg::ST_IDLE: begin
            ram_addr = count_ff[AB-1:0];
            if (take) begin
               if (!full) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + 1'b1;
                  sum_in   = sum_ff + amm_pkg::SUM_BITS'(req_sample[VB-1:0]);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_is_last) begin
                  i_in        = CB'(1);
                  div_done_in = 1'b0;
               end
            end
         end
         amm_pkg::ST_SORT_RD_I: begin
            ram_addr = i_ff[AB-1:0];
            j_in     = i_ff;
            if (i_ff == CB'(1)) begin
               dreq.start = 1'b1;
            end
         end
         amm_pkg::ST_SORT_RD_J: begin
            // On the first pass the read data is entry i, the key to insert.
            if (j_ff == i_ff) begin
               key_in = ram_rdata;
            end
            ram_addr = AB'(j_ff - 1'b1);
         end
         amm_pkg::ST_SORT_CMP: begin
            ram_addr = j_ff[AB-1:0];
            if (ram_rdata > key_ff) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata;
            end
         end
         amm_pkg::ST_SORT_SHIFT: begin
            j_in = j_ff - 1'b1;
         end
         amm_pkg::ST_SORT_PUT: begin
            ram_addr  = j_ff[AB-1:0];
            ram_we    = 1'b1;
            ram_wdata = key_ff;
            i_in      = i_ff + 1'b1;
         end
         amm_pkg::ST_SCAN_RD: begin
            ram_addr    = '0;
            i_in        = '0;
            run_in      = '0;
            best_rep_in = '0;
            best_val_in = '0;
         end
         amm_pkg::ST_SCAN_CHK: begin
            // ram_rdata holds entry i_ff; issue read of the next one.
            ram_addr = AB'(i_ff + 1'b1);
            if (i_ff != n_eff) begin
               i_in    = i_ff + 1'b1;
               prev_in = ram_rdata;
               if (i_ff == mid_lo) begin
                  med_in = amm_pkg::MED_BITS'(ram_rdata);
               end
               if (i_ff == mid_hi) begin
                  med_in = (i_ff == mid_lo) ?
                           amm_pkg::MED_BITS'({ram_rdata, 1'b0}) :
                           med_ff + amm_pkg::MED_BITS'(ram_rdata);
               end
               if (i_ff != '0 && ram_rdata == prev_ff) begin
                  run_in = run_ff + 1'b1;
                  if (run_ff + 1'b1 > best_rep_ff) begin
                     best_rep_in = run_ff + 1'b1;
                     best_val_in = ram_rdata;
                  end
               end else begin
                  run_in = '0;
               end
            end
         end
         amm_pkg::ST_DONE: begin
            count_in = '0;
            sum_in   = '0;
            drop_in  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= amm_pkg::ST_IDLE;
         count_ff    <= '0;
         sum_ff      <= '0;
         drop_ff     <= 1'b0;
         div_done_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         drop_ff     <= drop_in;
         div_done_ff <= div_done_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      key_ff      <= key_in;
      prev_ff     <= prev_in;
      run_ff      <= run_in;
      best_rep_ff <= best_rep_in;
      best_val_ff <= best_val_in;
      med_ff      <= med_in;
      mean_ff     <= mean_in;
   end

   // Outputs.
   assign busy               = (state_ff != amm_pkg::ST_IDLE);
   assign rsp_valid          = (state_ff == amm_pkg::ST_DONE);
   assign rsp_item_count     = 7'(count_ff);
   assign rsp_total          = sum_ff;
   assign rsp_mean_fixed     = mean_ff;
   assign rsp_median_doubled = med_ff;
   assign rsp_mode_value     = best_val_ff;
   assign rsp_mode_repeats   = best_rep_ff;
   assign rsp_has_mode       = (best_rep_ff != '0);
   assign rsp_overflowed     = drop_ff;

endmodule

@@ design/amm_checker.sv @@
// ----------------------------------------------------------------------------
// amm_checker: port-level checks for the statistics block.
// Watches the command handshake and the result strobe.
// ----------------------------------------------------------------------------
module amm_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_is_last,
   input logic       rsp_valid,
   input logic [6:0] rsp_item_count,
   input logic       rsp_has_mode,
   input logic [5:0] rsp_mode_repeats
);

   // A closing word makes the block busy.
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_is_last |=> busy)
      else $error("closing word did not start processing");

   // A plain word leaves the block free.
   a_plain_free: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_is_last |=> !busy)
      else $error("plain word made the block busy");

   // The result frees the block next cycle.
   a_valid_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("block stayed busy after result");

   // A result has a non-empty set and a consistent mode flag.
   a_result_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item_count != 7'd0 &&
                    rsp_has_mode == (rsp_mode_repeats != 6'd0))
      else $error("result fields inconsistent");

endmodule

bind array_mean_median_mode amm_checker u_amm_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_is_last      (req_is_last),
   .rsp_valid        (rsp_valid),
   .rsp_item_count   (rsp_item_count),
   .rsp_has_mode     (rsp_has_mode),
   .rsp_mode_repeats (rsp_mode_repeats)
);
